// File: rtl/core/aavc_pkg.sv
package aavc_pkg;

  localparam int unsigned ENTRIES_DEF    = 64;
  localparam int unsigned MAX_DATA_BYTES = 14;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned AGE_W  = 32;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned LO_W   = 64;
  localparam int unsigned HI_W   = 48;
  localparam int unsigned CFG_W  = 7;

  localparam logic [CFG_W-1:0] CAP_LIMIT_RST = CFG_W'(64);

  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [LO_W-1:0]   lo;
    logic [HI_W-1:0]   hi;
    logic [AGE_W-1:0]  stamp;
  } slot_t;

  typedef struct packed {
    logic             found;
    logic             evicted;
    logic [LEN_W-1:0] len;
    logic [LO_W-1:0]  lo;
    logic [HI_W-1:0]  hi;
  } rsp_t;

  function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] n);
    sat_len = (n > LEN_W'(MAX_DATA_BYTES)) ? LEN_W'(MAX_DATA_BYTES) : n;
  endfunction

  function automatic logic [LO_W-1:0] mask_low(logic [LEN_W-1:0] n);
    logic [LO_W-1:0] m;
    m = '0;
    for (int b = 0; b < LO_W / 8; b++) begin
      m[8*b +: 8] = (n > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    mask_low = m;
  endfunction

  function automatic logic [HI_W-1:0] mask_high(logic [LEN_W-1:0] n);
    logic [HI_W-1:0] m;
    m = '0;
    for (int b = 0; b < HI_W / 8; b++) begin
      m[8*b +: 8] = (n > LEN_W'(b + LO_W / 8)) ? 8'hFF : 8'h00;
    end
    mask_high = m;
  endfunction

endpackage

// File: rtl/core/aavc_req_if.sv
interface aavc_req_if;
  logic                         valid;
  logic                         ready;
  logic [aavc_pkg::ACT_W-1:0]   action;
  logic [aavc_pkg::ADDR_W-1:0]  group_address;
  logic signed [aavc_pkg::AGE_W-1:0] max_age;
  logic [aavc_pkg::LEN_W-1:0]   value_length;
  logic [aavc_pkg::LO_W-1:0]    value_low_bytes;
  logic [aavc_pkg::HI_W-1:0]    value_high_bytes;

  modport source (
    output valid, action, group_address, max_age, value_length, value_low_bytes,
           value_high_bytes,
    input  ready
  );
  modport sink (
    input  valid, action, group_address, max_age, value_length, value_low_bytes,
           value_high_bytes,
    output ready
  );
endinterface

// File: rtl/core/aavc_rsp_if.sv
interface aavc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       evicted;
  logic [aavc_pkg::LEN_W-1:0] result_length;
  logic [aavc_pkg::LO_W-1:0]  result_low_bytes;
  logic [aavc_pkg::HI_W-1:0]  result_high_bytes;

  modport source (
    output valid, found, evicted, result_length, result_low_bytes, result_high_bytes,
    input  ready
  );
  modport sink (
    input  valid, found, evicted, result_length, result_low_bytes, result_high_bytes,
    output ready
  );
endinterface

// File: rtl/core/aavc_ram.sv
module aavc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/aged_address_value_cache.sv
// Channel  Dir  Handshake    Word
// req_i    in   valid/ready  action, group_address, max_age, value_length, value_*_bytes
// rsp_o    out  valid/ready  found, evicted, result_length, result_*_bytes
// cfg      in   cfg_we_i     cfg_wdata_i -> capacity limit
//
// Lookup, remove and update walk the slot and rank memories once, one slot a cycle; an
// update then passes through a write state. A remove hit, or an update that replaces or
// evicts a slot, walks the rank memory again.
// Clear, tick and unknown actions skip the walk and go straight to the response state.
// Reset clears valid bits, live count and seconds and sets the capacity limit to 64; no sweep.
// A new word is taken while a result waits; the next one holds in RESP until it leaves.
module aged_address_value_cache #(
  parameter int unsigned ENTRIES = aavc_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [aavc_pkg::CFG_W-1:0] cfg_wdata_i,
  aavc_req_if.sink                   req_i,
  aavc_rsp_if.source                 rsp_o
);

  import aavc_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_DROP  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   live_q, live_d;
  logic [AGE_W-1:0]   seconds_q, seconds_d;
  logic [CFG_W-1:0]   cfg_q, cfg_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic               issue_q, issue_d;
  logic               chk_q, chk_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic               hit_q, hit_d;
  logic               old_q, old_d;
  logic               free_q, free_d;
  logic               found_q, found_d;
  logic               evicted_q, evicted_d;
  logic               rsp_valid_q, rsp_valid_d;

  logic [ACT_W-1:0]   act_q, act_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [AGE_W-1:0]   age_q, age_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LO_W-1:0]    lo_q, lo_d;
  logic [HI_W-1:0]    hi_q, hi_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]   hit_rank_q, hit_rank_d;
  logic [IDX_W-1:0]   old_idx_q, old_idx_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [IDX_W-1:0]   victim_idx_q, victim_idx_d;
  logic [IDX_W-1:0]   victim_rank_q, victim_rank_d;
  slot_t              cap_q, cap_d;
  rsp_t               rsp_q, rsp_d;

  slot_t              slot_rd, slot_wr;
  logic               slot_we;
  logic [IDX_W-1:0]   rank_rd, rank_wdata, rank_waddr;
  logic               rank_we;

  logic [LIM_W-1:0]   cfg_ext, limit;
  logic               full;
  logic [AGE_W-1:0]   age_diff;
  logic               fresh;

  aavc_ram #(.WIDTH($bits(slot_t)), .DEPTH(ENTRIES)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (free_idx_q),
    .wdata_i (slot_wr),
    .raddr_i (ptr_q),
    .rdata_o (slot_rd)
  );

  aavc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .raddr_i (ptr_q),
    .rdata_o (rank_rd)
  );

  assign slot_wr = '{addr: addr_q, len: len_q, lo: lo_q, hi: hi_q, stamp: seconds_q};

  always_comb begin
    cfg_ext = LIM_W'(cfg_q);
    if (cfg_ext == '0) begin
      limit = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(ENTRIES)) begin
      limit = LIM_W'(ENTRIES);
    end else begin
      limit = cfg_ext;
    end
    full     = (LIM_W'(live_q) >= limit);
    age_diff = seconds_q - cap_q.stamp;
    fresh    = age_q[AGE_W-1] || (age_diff <= age_q);
  end

  always_comb begin
    logic [IDX_W-1:0] v_idx;
    logic             do_drop;
    v_idx   = hit_idx_q;
    do_drop = 1'b0;

    state_d       = state_q;
    valid_d       = valid_q;
    live_d        = live_q;
    seconds_d     = seconds_q;
    cfg_d         = cfg_q;
    ptr_d         = ptr_q;
    issue_d       = issue_q;
    chk_d         = chk_q;
    chk_idx_d     = chk_idx_q;
    hit_d         = hit_q;
    old_d         = old_q;
    free_d        = free_q;
    found_d       = found_q;
    evicted_d     = evicted_q;
    rsp_valid_d   = rsp_valid_q;
    act_d         = act_q;
    addr_d        = addr_q;
    age_d         = age_q;
    len_d         = len_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    hit_idx_d     = hit_idx_q;
    hit_rank_d    = hit_rank_q;
    old_idx_d     = old_idx_q;
    free_idx_d    = free_idx_q;
    victim_idx_d  = victim_idx_q;
    victim_rank_d = victim_rank_q;
    cap_d         = cap_q;
    rsp_d         = rsp_q;
    slot_we       = 1'b0;
    rank_we       = 1'b0;
    rank_waddr    = chk_idx_q;
    rank_wdata    = rank_rd - 1'b1;

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    // memory walk: read at ptr, examine in the next cycle at chk_idx
    if (state_q == S_SRCH || state_q == S_DROP) begin
      chk_d     = issue_q;
      chk_idx_d = ptr_q;
      if (issue_q) begin
        if (ptr_q == LAST) begin
          issue_d = 1'b0;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d     = req_i.action;
          addr_d    = req_i.group_address;
          age_d     = req_i.max_age;
          len_d     = sat_len(req_i.value_length);
          lo_d      = req_i.value_low_bytes & mask_low(sat_len(req_i.value_length));
          hi_d      = req_i.value_high_bytes & mask_high(sat_len(req_i.value_length));
          hit_d     = 1'b0;
          old_d     = 1'b0;
          free_d    = 1'b0;
          found_d   = 1'b0;
          evicted_d = 1'b0;
          ptr_d     = '0;
          issue_d   = 1'b1;
          chk_d     = 1'b0;
          state_d   = S_RESP;
          unique case (req_i.action) inside
            ACT_UPDATE, ACT_LOOKUP, ACT_REMOVE: state_d = S_SRCH;
            ACT_CLEAR: begin
              valid_d = '0;
              live_d  = '0;
            end
            ACT_TICK: seconds_d = seconds_q + 1'b1;
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (chk_q) begin
          if (valid_q[chk_idx_q]) begin
            if (slot_rd.addr == addr_q) begin
              hit_d      = 1'b1;
              hit_idx_d  = chk_idx_q;
              hit_rank_d = rank_rd;
              cap_d      = slot_rd;
            end
            if (rank_rd == '0 && !old_q) begin
              old_d     = 1'b1;
              old_idx_d = chk_idx_q;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (chk_idx_q == LAST) begin
            state_d = S_DEC;
          end
        end
      end
      S_DEC: begin
        state_d = S_RESP;
        unique case (act_q)
          ACT_UPDATE: begin
            state_d = S_WRITE;
            if (hit_q) begin
              do_drop       = 1'b1;
              v_idx         = hit_idx_q;
              victim_rank_d = hit_rank_q;
            end else if (full && old_q) begin
              do_drop       = 1'b1;
              v_idx         = old_idx_q;
              victim_rank_d = '0;
              evicted_d     = 1'b1;
            end
            if (do_drop && !(free_q && free_idx_q < v_idx)) begin
              free_d     = 1'b1;
              free_idx_d = v_idx;
            end
          end
          ACT_LOOKUP: found_d = hit_q && fresh;
          ACT_REMOVE: begin
            do_drop       = hit_q;
            v_idx         = hit_idx_q;
            victim_rank_d = hit_rank_q;
          end
          default: ;
        endcase
        if (do_drop) begin
          valid_d[v_idx] = 1'b0;
          live_d         = live_q - 1'b1;
          victim_idx_d   = v_idx;
          ptr_d          = '0;
          issue_d        = 1'b1;
          chk_d          = 1'b0;
          state_d        = S_DROP;
        end
      end
      S_DROP: begin
        // close the rank gap left by the victim
        if (chk_q) begin
          if (valid_q[chk_idx_q] && rank_rd > victim_rank_q) begin
            rank_we = 1'b1;
          end
          if (chk_idx_q == LAST) begin
            state_d = (act_q == ACT_UPDATE) ? S_WRITE : S_RESP;
          end
        end
      end
      S_WRITE: begin
        if (free_q) begin
          slot_we             = 1'b1;
          rank_we             = 1'b1;
          rank_waddr          = free_idx_q;
          rank_wdata          = IDX_W'(live_q);
          valid_d[free_idx_q] = 1'b1;
          live_d              = live_q + 1'b1;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d   = 1'b1;
          rsp_d.found   = found_q;
          rsp_d.evicted = evicted_q;
          rsp_d.len     = found_q ? cap_q.len : '0;
          rsp_d.lo      = found_q ? cap_q.lo : '0;
          rsp_d.hi      = found_q ? cap_q.hi : '0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      live_q      <= '0;
      seconds_q   <= '0;
      cfg_q       <= CAP_LIMIT_RST;
      ptr_q       <= '0;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      chk_idx_q   <= '0;
      hit_q       <= 1'b0;
      old_q       <= 1'b0;
      free_q      <= 1'b0;
      found_q     <= 1'b0;
      evicted_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      live_q      <= live_d;
      seconds_q   <= seconds_d;
      cfg_q       <= cfg_d;
      ptr_q       <= ptr_d;
      issue_q     <= issue_d;
      chk_q       <= chk_d;
      chk_idx_q   <= chk_idx_d;
      hit_q       <= hit_d;
      old_q       <= old_d;
      free_q      <= free_d;
      found_q     <= found_d;
      evicted_q   <= evicted_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    addr_q        <= addr_d;
    age_q         <= age_d;
    len_q         <= len_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    hit_idx_q     <= hit_idx_d;
    hit_rank_q    <= hit_rank_d;
    old_idx_q     <= old_idx_d;
    free_idx_q    <= free_idx_d;
    victim_idx_q  <= victim_idx_d;
    victim_rank_q <= victim_rank_d;
    cap_q         <= cap_d;
    rsp_q         <= rsp_d;
  end

  assign req_i.ready             = (state_q == S_IDLE);
  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.found             = rsp_q.found;
  assign rsp_o.evicted           = rsp_q.evicted;
  assign rsp_o.result_length     = rsp_q.len;
  assign rsp_o.result_low_bytes  = rsp_q.lo;
  assign rsp_o.result_high_bytes = rsp_q.hi;

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q == CNT_W'($countones(valid_q)))
    else $error("live count out of step with valid bits");

  a_write_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> free_q)
    else $error("update reached write without a free slot");

  a_victim_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DROP |-> !valid_q[victim_idx_q])
    else $error("victim slot still valid during rank walk");

  a_evict_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && evicted_q |-> act_q == ACT_UPDATE && !found_q)
    else $error("eviction flagged outside an update");

endmodule
